[hw/rtl/bht_pkg.sv]
// ----------------------------------------------------------------------------
// bht_pkg: shared definitions for the bucketed hash table
// Field widths, command and status codes, default sizing.
// ----------------------------------------------------------------------------
package bht_pkg;

   // Fixed field widths of the request and response beats
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int BUCKET_W = 4;

   // Default sizing
   localparam int NUM_BUCKETS_DEF  = 11;
   localparam int BUCKET_DEPTH_DEF = 8;
   localparam int KEY_BITS_DEF     = 16;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

[hw/rtl/bht_req_if.sv]
// ----------------------------------------------------------------------------
// bht_req_if: request channel
// Valid/ready channel carrying one command and key per beat.
// ----------------------------------------------------------------------------
interface bht_req_if
   import bht_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             command;
   logic [KEY_W-1:0] key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

[hw/rtl/bht_rsp_if.sv]
// ----------------------------------------------------------------------------
// bht_rsp_if: response channel
// Valid/ready channel carrying one status and bucket index per beat.
// ----------------------------------------------------------------------------
interface bht_rsp_if
   import bht_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BUCKET_W-1:0] bucket;

   modport source (output valid, output status, output bucket, input ready);
   modport sink   (input valid, input status, input bucket, output ready);
endinterface

[hw/rtl/bht_ram.sv]
// ----------------------------------------------------------------------------
// bht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bht_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 88,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bucketed_hash_table_top.sv]
// ----------------------------------------------------------------------------
// bucketed_hash_table_top: bounded-bucket hash table with modulo hashing
// Insert and search of keys; bucket = key mod NUM_BUCKETS.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus (sink): one beat = command (0 insert, 1 search) + key. Only the
//     low KEY_BITS bits of the key are used.
//   rsp_bus (source): exactly one beat per request = status + bucket.
//     status: 0 inserted, 1 found, 2 not found, 3 bucket full (dropped).
//     bucket is the bucket index, low 4 bits.
// Sequence:
//   accept, a quotient state (key times reciprocal on the shared
//   multiplier), a remainder state (key minus quotient times NUM_BUCKETS on
//   the same multiplier), a lookup state, a RAM read then a compare per
//   compared entry, and a finish state. An insert reads no entries; a search
//   compares at most BUCKET_DEPTH entries, stopping at the first match.
//   One request is in flight at a time; req_bus.ready is high only idle.
// Stall: the result sits in an output register; the block goes back to
//   idle and takes the next request while it waits. A second result waits
//   in the finish state until rsp_bus.ready frees the output register.
// Reset: synchronous, active high. Clears all fill counts and control;
//   the entry RAM is not cleared, entries at or above a bucket's fill
//   count are never read.
// ----------------------------------------------------------------------------
module bucketed_hash_table_top
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   bht_req_if.sink   req_bus,
   bht_rsp_if.source rsp_bus
);

   // Derived widths
   localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;   // stored key
   localparam int IDXW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int LOG_N   = $clog2(NUM_BUCKETS);
   localparam int SHIFT   = KW + LOG_N;                              // reciprocal scale
   localparam int MW      = SHIFT + 1;                               // multiplier B side
   localparam int PW      = KW + MW;                                 // full product
   localparam int DW      = (KW > IDXW) ? KW : IDXW;                 // remainder math
   localparam int SW      = $clog2(BUCKET_DEPTH + 1);                // fill count / slot
   localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // ceil(2^SHIFT / N): quotient is exact for every KW-bit key
   localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) + 64'(NUM_BUCKETS - 1))
                                         / 64'(NUM_BUCKETS));

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_HASH   = 7'b0000010,
      S_REDUCE = 7'b0000100,
      S_LOOKUP = 7'b0001000,
      S_READ   = 7'b0010000,
      S_CMP    = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [KW-1:0]       quot_ff, quot_in;
   logic [IDXW-1:0]     rem_ff, rem_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;

   // Per-bucket fill counts
   logic [SW-1:0]       fill_ff [NUM_BUCKETS];
   logic                fill_we;

   // Shared multiplier
   logic [KW-1:0]       mul_a;
   logic [MW-1:0]       mul_b;
   logic [PW-1:0]       mul_prod;
   logic [DW-1:0]       rem_full;

   logic [IDXW-1:0]     bucket_idx;
   logic [SW-1:0]       fill_sel;
   logic [SW-1:0]       slot_inc;
   logic [AW-1:0]       base_addr;

   // RAM port
   logic                ram_we;
   logic                ram_re;
   logic [AW-1:0]       ram_waddr;
   logic [AW-1:0]       ram_raddr;
   logic [KW-1:0]       ram_rdata;

   assign bucket_idx = rem_ff;
   assign fill_sel   = fill_ff[bucket_idx];
   assign slot_inc   = slot_ff + SW'(1);
   assign base_addr  = AW'(bucket_idx) * AW'(BUCKET_DEPTH);
   assign ram_waddr  = base_addr + AW'(fill_sel);
   assign ram_raddr  = base_addr + AW'(slot_ff);

   // Hash cycle: key * RECIP, quotient in the upper bits.
   // Reduce cycle: quotient * N, remainder = key - product (mod 2^DW).
   assign mul_a    = (state_ff == S_HASH) ? key_ff : quot_ff;
   assign mul_b    = (state_ff == S_HASH) ? RECIP : MW'(NUM_BUCKETS);
   assign mul_prod = PW'(mul_a) * PW'(mul_b);
   assign rem_full = DW'(key_ff) - mul_prod[DW-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      fill_we       = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in   = req_bus.command;
               key_in   = req_bus.key[KW-1:0];
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            quot_in  = mul_prod[SHIFT +: KW];
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            rem_in   = rem_full[IDXW-1:0];
            state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            slot_in = '0;
            if (cmd_ff == CMD_INSERT) begin
               if (fill_sel >= SW'(BUCKET_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  fill_we   = 1'b1;
                  status_in = ST_INSERTED;
               end
               state_in = S_FINISH;
            end else if (fill_sel == '0) begin
               status_in = ST_MISSING;
               state_in  = S_FINISH;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ram_rdata == key_ff) begin
               status_in = ST_FOUND;
               state_in  = S_FINISH;
            end else if (slot_inc >= fill_sel) begin
               status_in = ST_MISSING;
               state_in  = S_FINISH;
            end else begin
               slot_in  = slot_inc;
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            // Output register free, or freed by this cycle's handshake
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bucket_in = BUCKET_W'(bucket_idx);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fill_we) begin
            fill_ff[bucket_idx] <= fill_sel + SW'(1);
         end
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   bht_ram #(
      .WIDTH (KW),
      .DEPTH (ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (key_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.bucket = rsp_bucket_ff;

endmodule
